// ===== src/serial_sram_spi_slave_macros.svh =====
`ifndef SERIAL_SRAM_SPI_SLAVE_MACROS_SVH
`define SERIAL_SRAM_SPI_SLAVE_MACROS_SVH

// Checks that a condition never holds at a clock edge outside reset.
`define SSPI_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define SSPI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

// ===== src/sspi_pkg.sv =====
`timescale 1ns / 1ps

package sspi_pkg;

   localparam int MEM_BYTES_DEFAULT = 32768;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int ADDR_W = 16;

   localparam logic [7:0] CMD_WRSR = 8'h01;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_RDSR = 8'h05;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_DATA,
      PH_STAT_WR,
      PH_STAT_RD,
      PH_IGNORE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_WRITE,
      KIND_READ,
      KIND_STATUS
   } kind_type;

   typedef enum logic [1:0] {
      OP_ZERO,
      OP_STATUS,
      OP_WRITE,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } op_type;

endpackage

// ===== src/sspi_ram.sv =====
`timescale 1ns / 1ps

module sspi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/sspi_fifo.sv =====
`timescale 1ns / 1ps

module sspi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rptr_ff];
   assign count = count_ff;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/sspi_front.sv =====
`timescale 1ns / 1ps

module sspi_front
   import sspi_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       queue_full,
   output logic       req_full,
   input  logic       first_byte,
   input  logic [7:0] mosi_byte,
   output logic       op_valid,
   output op_type     op
);

   localparam int AW = $clog2(MEM_BYTES);

   phase_type     phase_ff, phase_in;
   kind_type      kind_ff, kind_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] hi_rem_ff, hi_rem_in;
   logic [7:0]    status_ff, status_in;
   logic [AW-1:0] hi_rem_table [256];
   logic [AW:0]   lo_sum;
   logic [AW-1:0] wrap_rem;
   logic          accept;

   assign accept = req_push && !queue_full;
   assign req_full = queue_full;
   assign op_valid = accept;

   // The high address byte is reduced through a constant table, so adding the low byte
   // needs at most one subtraction to stay below the memory size.
   for (genvar g = 0; g < 256; g++) begin : g_hi_rem
      assign hi_rem_table[g] = AW'((g * 256) % MEM_BYTES);
   end

   assign lo_sum = {1'b0, hi_rem_ff} + (AW + 1)'(mosi_byte);
   assign wrap_rem = (lo_sum >= (AW + 1)'(MEM_BYTES)) ?
                     AW'(lo_sum - (AW + 1)'(MEM_BYTES)) : AW'(lo_sum);

   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      cursor_in = cursor_ff;
      hi_rem_in = hi_rem_ff;
      status_in = status_ff;
      op.kind = OP_ZERO;
      op.addr = ADDR_W'(cursor_ff);
      op.data = '0;
      if (accept) begin
         if (first_byte) begin
            case (mosi_byte)
               CMD_WRSR: begin
                  phase_in = PH_STAT_WR;
                  kind_in = KIND_STATUS;
               end
               CMD_WRITE: begin
                  phase_in = PH_ADDR_HI;
                  kind_in = KIND_WRITE;
               end
               CMD_READ: begin
                  phase_in = PH_ADDR_HI;
                  kind_in = KIND_READ;
               end
               CMD_RDSR: begin
                  phase_in = PH_STAT_RD;
                  kind_in = KIND_STATUS;
               end
               default: begin
                  phase_in = PH_IGNORE;
                  kind_in = KIND_NONE;
               end
            endcase
         end else begin
            case (phase_ff)
               PH_ADDR_HI: begin
                  hi_rem_in = hi_rem_table[mosi_byte];
                  phase_in = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  cursor_in = wrap_rem;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (kind_ff == KIND_WRITE) begin
                     op.kind = OP_WRITE;
                     op.data = mosi_byte;
                  end else if (kind_ff == KIND_READ) begin
                     op.kind = OP_READ;
                  end
                  cursor_in = (cursor_ff == AW'(MEM_BYTES - 1)) ? '0 : cursor_ff + 1'b1;
               end
               PH_STAT_WR: begin
                  status_in = mosi_byte;
                  phase_in = PH_IGNORE;
               end
               PH_STAT_RD: begin
                  op.kind = OP_STATUS;
                  op.data = status_ff;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff <= KIND_NONE;
         cursor_ff <= '0;
         hi_rem_ff <= '0;
         status_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         cursor_ff <= cursor_in;
         hi_rem_ff <= hi_rem_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== src/sspi_back.sv =====
`timescale 1ns / 1ps

module sspi_back
   import sspi_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             op_empty,
   input  op_type                           op,
   output logic                             op_pop,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] out_count,
   output logic                             out_push,
   output logic [7:0]                       out_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic       valid_ff, valid_in;
   logic       read_ff, read_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] ram_rdata;
   logic       ram_en, ram_we;

   // A word is taken only if the result queue has room for it and the one in flight.
   assign op_pop = !op_empty &&
                   (({1'b0, out_count} + (CW + 1)'(valid_ff)) < (CW + 1)'(QUEUE_DEPTH));
   assign ram_en = op_pop && (op.kind == OP_READ || op.kind == OP_WRITE);
   assign ram_we = (op.kind == OP_WRITE);
   assign valid_in = op_pop;
   assign read_in = (op.kind == OP_READ);
   assign data_in = (op.kind == OP_STATUS) ? op.data : 8'd0;

   sspi_ram #(
      .WIDTH(8),
      .DEPTH(MEM_BYTES)
   ) u_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (op.addr[AW-1:0]),
      .wdata(op.data),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         read_ff <= read_in;
         data_ff <= data_in;
      end
   end

   assign out_push = valid_ff;
   assign out_data = read_ff ? ram_rdata : data_ff;

endmodule

// ===== src/serial_sram_spi_slave.sv =====
// Each accepted word passes the op queue and the RAM stage to the rsp_ queue.
// Throughput: one word per cycle unless queues back up, set by the single RAM port.
// Queues of four words sit between the front end and the RAM stage and at the output.
// Reset is synchronous and active high; it clears the queues, the command state,
// the address cursor and the status register. The data RAM keeps its contents.
`timescale 1ns / 1ps
`include "serial_sram_spi_slave_macros.svh"

module serial_sram_spi_slave
   import sspi_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_first_byte,
   input  logic [7:0] req_mosi_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_miso_byte
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_type          front_op;
   op_type          mid_op;
   logic            front_valid;
   logic            mid_full, mid_empty, mid_pop;
   logic [CW-1:0]   out_count;
   logic            out_push, out_full;
   logic [7:0]      out_data;

   sspi_front #(
      .MEM_BYTES(MEM_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .queue_full(mid_full),
      .req_full  (req_full),
      .first_byte(req_first_byte),
      .mosi_byte (req_mosi_byte),
      .op_valid  (front_valid),
      .op        (front_op)
   );

   sspi_fifo #(
      .WIDTH($bits(op_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_op_queue (
      .clock(clock),
      .reset(reset),
      .push (front_valid),
      .wdata(front_op),
      .full (mid_full),
      .pop  (mid_pop),
      .rdata(mid_op),
      .empty(mid_empty),
      .count()
   );

   sspi_back #(
      .MEM_BYTES  (MEM_BYTES),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (mid_empty),
      .op       (mid_op),
      .op_pop   (mid_pop),
      .out_count(out_count),
      .out_push (out_push),
      .out_data (out_data)
   );

   sspi_fifo #(
      .WIDTH(8),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .wdata(out_data),
      .full (out_full),
      .pop  (rsp_pop),
      .rdata(rsp_miso_byte),
      .empty(rsp_empty),
      .count(out_count)
   );

   `SSPI_ASSERT_NEVER(a_rsp_overflow, out_push && out_full, "Result word pushed into a full queue.")
   `SSPI_ASSERT_NEVER(a_pop_no_room, mid_pop && out_full, "Operation taken with no result room.")
   `SSPI_ASSERT_NEXT(a_accept_queued, req_push && !req_full, !mid_empty, "Accepted word not queued.")
   `SSPI_ASSERT_NEXT(a_result_shown, out_push, !rsp_empty, "Result word not visible after push.")

endmodule
